// ===== sv/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  localparam int GainFracBits = 30;
  localparam int GainW        = GainFracBits + 1;
  localparam int StepW        = GainW + 1;
  localparam int SampleW      = 16;
  localparam int ProdW        = SampleW + StepW;
  localparam int LenW         = 20;
  localparam int SusW         = 17;
  localparam int SusFracBits  = 16;
  localparam int LeftW        = 31;
  localparam int CntW         = $clog2(GainW + 1);
  localparam int CfgIdxW      = 2;
  localparam int SampleMax    = 32767;
  localparam int SampleMin    = -32768;

  localparam logic [LeftW-1:0] HoldCount = LeftW'(1) << 30;
  localparam logic [GainW-1:0] UnityGain = GainW'(1) << GainFracBits;
  localparam logic [SusW-1:0]  SusUnity  = SusW'(1) << SusFracBits;

  typedef enum logic [1:0] {
    OpSample  = 2'd0,
    OpTick    = 2'd1,
    OpNoteOn  = 2'd2,
    OpNoteOff = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAttack  = 2'd0,
    CfgDecay   = 2'd1,
    CfgRelease = 2'd2,
    CfgSustain = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TgtZero    = 2'd0,
    TgtUnity   = 2'd1,
    TgtSustain = 2'd2
  } tgt_e;

  typedef enum logic [1:0] {
    LenAttack  = 2'd0,
    LenDecay   = 2'd1,
    LenRelease = 2'd2
  } len_e;

  typedef struct packed {
    logic cap;
    logic mul;
    logic out_ld;
    logic out_zero;
    logic adv;
    logic seg_start;
    tgt_e tgt;
    len_e seg_len;
    logic div_step;
    logic div_fin;
    logic sus_enter;
    logic hold;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic left_zero;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/adsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_ctrl
  import adsr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic [1:0] op_i,
  output logic            s_ready_o,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StOut  = 6'b000100,
    StAdv  = 6'b001000,
    StEnd  = 6'b010000,
    StDiv  = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhAttack  = 5'b00010,
    PhDecay   = 5'b00100,
    PhSustain = 5'b01000,
    PhRelease = 5'b10000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   env_idle;

  assign env_idle  = (phase_q == PhIdle);
  assign s_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          unique case (op_e'(op_i))
            OpSample: begin
              cmd_o.cap = 1'b1;
              state_d   = env_idle ? StOut : StMul;
            end
            OpTick: begin
              if (!env_idle) state_d = StAdv;
            end
            OpNoteOn: begin
              phase_d         = PhAttack;
              cmd_o.seg_start = 1'b1;
              cmd_o.tgt       = TgtUnity;
              cmd_o.seg_len   = LenAttack;
              state_d         = StDiv;
            end
            OpNoteOff: begin
              if (!env_idle) begin
                phase_d         = PhRelease;
                cmd_o.seg_start = 1'b1;
                cmd_o.tgt       = TgtZero;
                cmd_o.seg_len   = LenRelease;
                state_d         = StDiv;
              end
            end
            default: ;
          endcase
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_zero = env_idle;
          state_d        = env_idle ? StIdle : StAdv;
        end
      end
      StAdv: begin
        cmd_o.adv = 1'b1;
        state_d   = StEnd;
      end
      StEnd: begin
        state_d = StIdle;
        if (sts_i.left_zero) begin
          unique case (phase_q)
            PhAttack: begin
              phase_d         = PhDecay;
              cmd_o.seg_start = 1'b1;
              cmd_o.tgt       = TgtSustain;
              cmd_o.seg_len   = LenDecay;
              state_d         = StDiv;
            end
            PhDecay: begin
              phase_d         = PhSustain;
              cmd_o.sus_enter = 1'b1;
            end
            PhRelease: begin
              phase_d   = PhIdle;
              cmd_o.clr = 1'b1;
            end
            default: cmd_o.hold = 1'b1;
          endcase
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_d       = StIdle;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhIdle;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/adsr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_dp
  import adsr_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [LenW-1:0]           cfg_data_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire cmd_t                      cmd_i,
  output sts_t                           sts_o,
  output logic                           m_valid_o,
  input  wire logic                      m_ready_i,
  output logic signed [SampleW-1:0]      m_data_o
);

  logic [LenW-1:0] attack_q, decay_q, release_q;
  logic [SusW-1:0] sus_q;

  logic [GainW-1:0]        gain_q, gain_d;
  logic signed [StepW-1:0] step_q, step_d;
  logic [LeftW-1:0]        left_q, left_d;

  logic signed [SampleW-1:0] samp_q;
  logic signed [ProdW-1:0]   prod_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic [LenW-1:0]  rem_q, rem_d, div_q;
  logic [GainW-1:0] quo_q, quo_d;
  logic             neg_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [SusW-1:0]         sus_clamp;
  logic [GainW-1:0]        sus_level, tgt_val;
  logic [LenW-1:0]         len_raw, len_n;
  logic signed [StepW-1:0] diff;
  logic [StepW-1:0]        diff_mag;
  logic signed [StepW:0]   gain_sum;
  logic [LenW:0]           rem_sh;
  logic                    ge;
  logic signed [ProdW-1:0] bias, biased, shifted;
  logic signed [SampleW-1:0] sat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= LenW'(463);
      decay_q   <= LenW'(1544);
      release_q <= LenW'(13230);
      sus_q     <= SusW'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgAttack:  attack_q  <= cfg_data_i;
        CfgDecay:   decay_q   <= cfg_data_i;
        CfgRelease: release_q <= cfg_data_i;
        CfgSustain: sus_q     <= cfg_data_i[SusW-1:0];
        default: ;
      endcase
    end
  end

  assign sus_clamp = (sus_q > SusUnity) ? SusUnity : sus_q;
  assign sus_level = GainW'(sus_clamp) << (GainFracBits - SusFracBits);

  always_comb begin
    case (cmd_i.tgt)
      TgtUnity:   tgt_val = UnityGain;
      TgtSustain: tgt_val = sus_level;
      default:    tgt_val = '0;
    endcase
    case (cmd_i.seg_len)
      LenAttack: len_raw = attack_q;
      LenDecay:  len_raw = decay_q;
      default:   len_raw = release_q;
    endcase
  end

  assign len_n    = (len_raw == '0) ? LenW'(1) : len_raw;
  assign diff     = $signed({1'b0, tgt_val}) - $signed({1'b0, gain_q});
  assign diff_mag = diff[StepW-1] ? StepW'(-diff) : StepW'(diff);
  assign gain_sum = $signed({2'b00, gain_q}) + $signed({step_q[StepW-1], step_q});

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_q, quo_q[GainW-1]};
  assign ge     = (rem_sh >= {1'b0, div_q});

  always_comb begin
    gain_d = gain_q;
    step_d = step_q;
    left_d = left_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    if (cmd_i.adv) begin
      gain_d = gain_sum[StepW] ? '0 : gain_sum[GainW-1:0];
      if (left_q != '0) left_d = left_q - LeftW'(1);
    end
    if (cmd_i.seg_start) begin
      left_d = LeftW'(len_n);
      rem_d  = '0;
      quo_d  = diff_mag[GainW-1:0];
      cnt_d  = CntW'(GainW);
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? LenW'(rem_sh - {1'b0, div_q}) : rem_sh[LenW-1:0];
      quo_d = {quo_q[GainW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.div_fin) begin
      step_d = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
    if (cmd_i.sus_enter) begin
      gain_d = sus_level;
      step_d = '0;
      left_d = HoldCount;
    end
    if (cmd_i.hold) begin
      step_d = '0;
      left_d = HoldCount;
    end
    if (cmd_i.clr) begin
      gain_d = '0;
      step_d = '0;
      left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      step_q <= '0;
      left_q <= '0;
      cnt_q  <= '0;
    end else begin
      gain_q <= gain_d;
      step_q <= step_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.seg_start) begin
      div_q <= len_n;
      neg_q <= diff[StepW-1];
    end
    if (cmd_i.cap) samp_q <= sample_i;
    if (cmd_i.mul) prod_q <= samp_q * $signed({1'b0, gain_q});
  end

  // truncate toward zero, then saturate
  assign bias    = prod_q[ProdW-1] ? ProdW'((64'sd1 <<< GainFracBits) - 64'sd1) : '0;
  assign biased  = prod_q + bias;
  assign shifted = biased >>> GainFracBits;

  always_comb begin
    if (shifted > ProdW'(SampleMax)) begin
      sat = SampleW'(SampleMax);
    end else if (shifted < ProdW'(SampleMin)) begin
      sat = SampleW'(SampleMin);
    end else begin
      sat = shifted[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) out_q <= cmd_i.out_zero ? '0 : sat;
  end

  assign m_valid_o       = out_valid_q;
  assign m_data_o        = out_q;
  assign sts_o.out_free  = !out_valid_q || m_ready_i;
  assign sts_o.left_zero = (left_q == '0);
  assign sts_o.div_done  = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== sv/adsr_envelope_gain_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Linear ADSR envelope applied to a signed 16-bit audio stream. Each input word
// carries an op in tuser (sample, silent tick, note on, note off) and a sample in
// tdata; only audio samples produce an output word, the sample times the Q1.30
// gain, truncated toward zero and saturated (zero while the envelope is idle).
// A sample passes capture, multiply, output load (held until the output register
// is free), gain update and segment-end check before the next ready; only capture
// and output load while the envelope is idle. A note on, a note off, or a sample
// or tick ending the attack segment also runs the serial ramp-step divider, one
// quotient bit per cycle. The output register lets the next word be accepted
// while a result waits on the master side. Ramp lengths and the sustain level are
// to be written through the cfg port only while idle; the block does not check it.

module adsr_envelope_gain_top
  import adsr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [LenW-1:0]    cfg_data_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [15:0]        s_axis_tdata_i,  // sample_in
  input  wire logic [1:0]         s_axis_tuser_i,  // op
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [15:0]             m_axis_tdata_o   // sample_out
);

  cmd_t cmd;
  sts_t sts;
  logic signed [SampleW-1:0] out_data;

  adsr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .op_i      (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  adsr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   ($signed(s_axis_tdata_i)),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (out_data)
  );

  assign m_axis_tdata_o = out_data;

endmodule

`default_nettype wire

// ===== sv/adsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_checker
  import adsr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid_i,
  input wire logic               s_axis_tready_o,
  input wire logic [1:0]         s_axis_tuser_i,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [15:0]        m_axis_tdata_o
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // a result never appears in the cycle right after its input is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o))
    else $error("output word raised too early");

  // an accepted audio sample always drops ready, as the block moves on to the multiply or output state
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser_i == OpSample)) |=> !s_axis_tready_o)
    else $error("ready right after a sample word");

endmodule

bind adsr_envelope_gain_top adsr_checker u_checker (.*);

`default_nettype wire
